### rtl/ktd_pkg.sv
// Shared constants and types for the Kendall tau distance block.
package ktd_pkg;

	// Width of one permutation element and of the distance result.
	localparam int ELEM_W = 8;
	localparam int DIST_W = 15;
	localparam int DIST_MAX = (2 ** DIST_W) - 1;

	// Default capacity in pairs.
	localparam int DEF_MAX_SIZE = 256;

	// The value bitmaps are kept as words of 32 flags.
	localparam int BM_LOG = 5;
	localparam int BM_W = 2 ** BM_LOG;
	localparam int PC_W = BM_LOG + 1;

	// Memory requests issued by the inversion walk.
	typedef struct packed {
		logic inv_rd;
		logic first_rd;
		logic bm_rd;
		logic bm_wr;
	} wk_ctl_t;

endpackage

### rtl/ktd_perm_store.sv
// Memories for the first permutation and the inverse of the second one.
module ktd_perm_store #(
	parameter int MAX_SIZE = ktd_pkg::DEF_MAX_SIZE,
	localparam int IDX_W = $clog2(MAX_SIZE)
) (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [IDX_W-1:0]            wr_pos,
	input  logic [ktd_pkg::ELEM_W-1:0]  wr_first,
	input  logic [IDX_W-1:0]            wr_val,
	input  logic [ktd_pkg::ELEM_W-1:0]  wr_inv,
	input  ktd_pkg::wk_ctl_t            ctl,
	input  logic [IDX_W-1:0]            inv_addr,
	input  logic [IDX_W-1:0]            first_addr,
	output logic [ktd_pkg::ELEM_W-1:0]  inv_q,
	output logic [ktd_pkg::ELEM_W-1:0]  first_q
);
	import ktd_pkg::*;

	logic [ELEM_W-1:0] first_mem [MAX_SIZE];
	logic [ELEM_W-1:0] inv_mem [MAX_SIZE];

	// During loading, the first value lands at its position and the position
	// lands at the second value, which builds the inverse permutation.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			first_mem[wr_pos] <= wr_first;
			inv_mem[wr_val] <= wr_inv;
		end
	end

	// Registered reads for the walk; each output holds until its next read.
	always_ff @(posedge clk) begin
		if (ctl.inv_rd) begin
			inv_q <= inv_mem[inv_addr];
		end
		if (ctl.first_rd) begin
			first_q <= first_mem[first_addr];
		end
	end

endmodule

### rtl/ktd_bitmap.sv
// Value bitmaps: seen flags for both permutations, reused as the visited map.
module ktd_bitmap #(
	parameter int MAX_SIZE = ktd_pkg::DEF_MAX_SIZE,
	localparam int CNT_W = $clog2(MAX_SIZE + 1),
	localparam int NWORDS = (MAX_SIZE + ktd_pkg::BM_W - 1) / ktd_pkg::BM_W,
	localparam int WA_W = (NWORDS > 1) ? $clog2(NWORDS) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        ld_en,
	input  logic [ktd_pkg::ELEM_W-1:0]  ld_a,
	input  logic [ktd_pkg::ELEM_W-1:0]  ld_b,
	input  logic                        stat_clr,
	input  logic                        clr_en,
	input  logic [WA_W-1:0]             clr_addr,
	input  ktd_pkg::wk_ctl_t            wk_ctl,
	input  logic [WA_W-1:0]             wk_addr,
	input  logic [ktd_pkg::BM_W-1:0]    wk_wdata,
	output logic [ktd_pkg::BM_W-1:0]    rd_data,
	output logic [CNT_W-1:0]            cnt_a,
	output logic [CNT_W-1:0]            cnt_b,
	output logic [ktd_pkg::ELEM_W-1:0]  max_a,
	output logic [ktd_pkg::ELEM_W-1:0]  max_b
);
	import ktd_pkg::*;

	logic [BM_W-1:0] bm_a_mem [NWORDS];
	logic [BM_W-1:0] bm_b_mem [NWORDS];

	logic [WA_W-1:0]   aw;
	logic [WA_W-1:0]   bw;
	logic [BM_W-1:0]   rd_a_q;
	logic [BM_W-1:0]   rd_b_q;
	logic              v_s1;
	logic [WA_W-1:0]   aw_s1;
	logic [WA_W-1:0]   bw_s1;
	logic [BM_LOG-1:0] ab_s1;
	logic [BM_LOG-1:0] bb_s1;
	logic              fwd_v_q;
	logic [WA_W-1:0]   fwd_aw_q;
	logic [WA_W-1:0]   fwd_bw_q;
	logic [BM_W-1:0]   fwd_a_q;
	logic [BM_W-1:0]   fwd_b_q;
	logic [BM_W-1:0]   base_a;
	logic [BM_W-1:0]   base_b;
	logic [BM_W-1:0]   bit_a;
	logic [BM_W-1:0]   bit_b;
	logic [BM_W-1:0]   new_a;
	logic [BM_W-1:0]   new_b;
	logic              fresh_a;
	logic              fresh_b;

	assign aw = WA_W'(ld_a >> BM_LOG);
	assign bw = WA_W'(ld_b >> BM_LOG);
	assign rd_data = rd_a_q;

	// Read port; the walk owns the first bitmap after loading has drained.
	always_ff @(posedge clk) begin
		if (wk_ctl.bm_rd) begin
			rd_a_q <= bm_a_mem[wk_addr];
		end else if (ld_en) begin
			rd_a_q <= bm_a_mem[aw];
		end
		if (ld_en) begin
			rd_b_q <= bm_b_mem[bw];
		end
	end

	// Load stage that waits for the read words.
	always_ff @(posedge clk) begin
		aw_s1 <= aw;
		bw_s1 <= bw;
		ab_s1 <= ld_a[BM_LOG-1:0];
		bb_s1 <= ld_b[BM_LOG-1:0];
		fwd_aw_q <= aw_s1;
		fwd_bw_q <= bw_s1;
		fwd_a_q <= new_a;
		fwd_b_q <= new_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			fwd_v_q <= 1'b0;
		end else begin
			v_s1 <= ld_en;
			fwd_v_q <= v_s1;
		end
	end

	// A word written on the previous edge is newer than the word just read.
	always_comb begin
		base_a = (fwd_v_q && fwd_aw_q == aw_s1) ? fwd_a_q : rd_a_q;
		base_b = (fwd_v_q && fwd_bw_q == bw_s1) ? fwd_b_q : rd_b_q;
		bit_a = BM_W'(1) << ab_s1;
		bit_b = BM_W'(1) << bb_s1;
		new_a = base_a | bit_a;
		new_b = base_b | bit_b;
		fresh_a = ~|(base_a & bit_a);
		fresh_b = ~|(base_b & bit_b);
	end

	// Single write port per bitmap: clearing pass, walk update, or load update.
	always_ff @(posedge clk) begin
		if (clr_en) begin
			bm_a_mem[clr_addr] <= '0;
			bm_b_mem[clr_addr] <= '0;
		end else if (wk_ctl.bm_wr) begin
			bm_a_mem[wk_addr] <= wk_wdata;
		end else if (v_s1) begin
			bm_a_mem[aw_s1] <= new_a;
			bm_b_mem[bw_s1] <= new_b;
		end
	end

	// Distinct value counts and largest stored values of the current job.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_a <= '0;
			cnt_b <= '0;
			max_a <= '0;
			max_b <= '0;
		end else if (stat_clr) begin
			cnt_a <= '0;
			cnt_b <= '0;
			max_a <= '0;
			max_b <= '0;
		end else begin
			if (v_s1) begin
				cnt_a <= cnt_a + CNT_W'(fresh_a);
				cnt_b <= cnt_b + CNT_W'(fresh_b);
			end
			if (ld_en && ld_a > max_a) begin
				max_a <= ld_a;
			end
			if (ld_en && ld_b > max_b) begin
				max_b <= ld_b;
			end
		end
	end

endmodule

### rtl/ktd_walk.sv
// Inversion walk over the composed permutation, one position at a time.
module ktd_walk #(
	parameter int MAX_SIZE = ktd_pkg::DEF_MAX_SIZE,
	localparam int IDX_W = $clog2(MAX_SIZE),
	localparam int CNT_W = $clog2(MAX_SIZE + 1),
	localparam int NWORDS = (MAX_SIZE + ktd_pkg::BM_W - 1) / ktd_pkg::BM_W,
	localparam int WA_W = (NWORDS > 1) ? $clog2(NWORDS) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [CNT_W-1:0]            n,
	input  logic [ktd_pkg::ELEM_W-1:0]  inv_q,
	input  logic [ktd_pkg::ELEM_W-1:0]  first_q,
	input  logic [ktd_pkg::BM_W-1:0]    bm_data,
	output ktd_pkg::wk_ctl_t            ctl,
	output logic [IDX_W-1:0]            inv_addr,
	output logic [IDX_W-1:0]            first_addr,
	output logic [WA_W-1:0]             bm_addr,
	output logic [ktd_pkg::BM_W-1:0]    bm_wdata,
	output logic                        done,
	output logic [ktd_pkg::DIST_W-1:0]  distance
);
	import ktd_pkg::*;

	localparam logic [2:0] WK_IDLE  = 3'd0;
	localparam logic [2:0] WK_INV   = 3'd1;
	localparam logic [2:0] WK_FIRST = 3'd2;
	localparam logic [2:0] WK_SCAN  = 3'd3;
	localparam logic [2:0] WK_LAST  = 3'd4;

	logic [2:0]        st_q;
	logic [CNT_W-1:0]  i_q;
	logic [CNT_W-1:0]  i_nx;
	logic [CNT_W-1:0]  nl;
	logic [WA_W-1:0]   sa_q;
	logic              pend_q;
	logic [WA_W-1:0]   pend_w_q;
	logic [DIST_W-1:0] dist_q;
	logic              done_q;
	logic [WA_W-1:0]   cw;
	logic [BM_LOG-1:0] cb;
	logic [WA_W-1:0]   lw;
	logic [BM_LOG-1:0] lb;
	logic [BM_W-1:0]   above;
	logic [BM_W-1:0]   below;
	logic [BM_W-1:0]   hits;
	logic [PC_W-1:0]   hit_cnt;
	logic [DIST_W:0]   sum;

	function automatic logic [PC_W-1:0] popcnt(input logic [BM_W-1:0] v);
		logic [PC_W-1:0] s;
		s = '0;
		for (int k = 0; k < BM_W; k++) begin
			s = s + PC_W'(v[k]);
		end
		return s;
	endfunction

	// Word and bit of the composed value and of the last position.
	assign nl = n - CNT_W'(1);
	assign i_nx = i_q + CNT_W'(1);
	assign cw = WA_W'(first_q >> BM_LOG);
	assign cb = first_q[BM_LOG-1:0];
	assign lw = WA_W'(nl >> BM_LOG);
	assign lb = nl[BM_LOG-1:0];
	assign done = done_q;
	assign distance = dist_q;

	// A cleared flag below n marks a value already visited; count those above c.
	always_comb begin
		above = (pend_w_q == cw) ? ~((BM_W'(2) << cb) - BM_W'(1)) : '1;
		below = (pend_w_q == lw) ? ((BM_W'(2) << lb) - BM_W'(1)) : '1;
		hits = ~bm_data & above & below;
		hit_cnt = popcnt(hits);
		sum = {1'b0, dist_q} + (DIST_W + 1)'(hit_cnt);
	end

	// Memory requests for the current step.
	always_comb begin
		ctl = '0;
		inv_addr = IDX_W'(i_q);
		first_addr = IDX_W'(inv_q);
		bm_addr = sa_q;
		bm_wdata = bm_data & ~(BM_W'(1) << cb);
		unique case (st_q)
			WK_IDLE: begin
			end
			WK_INV: begin
				ctl.inv_rd = 1'b1;
			end
			WK_FIRST: begin
				ctl.first_rd = 1'b1;
			end
			WK_SCAN: begin
				ctl.bm_rd = 1'b1;
			end
			WK_LAST: begin
				// Mark c visited and fetch the next inverse entry in the same cycle.
				ctl.bm_wr = 1'b1;
				bm_addr = cw;
				ctl.inv_rd = (i_q != nl);
				inv_addr = IDX_W'(i_nx);
			end
			default: begin
			end
		endcase
	end

	// Accumulated distance, saturating at the field's top.
	always_ff @(posedge clk) begin
		if (st_q == WK_IDLE && start) begin
			dist_q <= '0;
		end else if (pend_q) begin
			dist_q <= sum[DIST_W] ? DIST_W'(DIST_MAX) : sum[DIST_W-1:0];
		end
	end

	// Walk sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= WK_IDLE;
			i_q <= '0;
			sa_q <= '0;
			pend_q <= 1'b0;
			pend_w_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				WK_IDLE: begin
					if (start) begin
						i_q <= '0;
						st_q <= WK_INV;
					end
				end
				WK_INV: begin
					st_q <= WK_FIRST;
				end
				WK_FIRST: begin
					sa_q <= lw;
					pend_q <= 1'b0;
					st_q <= WK_SCAN;
				end
				WK_SCAN: begin
					pend_q <= 1'b1;
					pend_w_q <= sa_q;
					if (sa_q == cw) begin
						st_q <= WK_LAST;
					end else begin
						sa_q <= sa_q - WA_W'(1);
					end
				end
				WK_LAST: begin
					pend_q <= 1'b0;
					if (i_q == nl) begin
						done_q <= 1'b1;
						st_q <= WK_IDLE;
					end else begin
						i_q <= i_nx;
						st_q <= WK_FIRST;
					end
				end
				default: begin
					st_q <= WK_IDLE;
				end
			endcase
		end
	end

endmodule

### rtl/kendall_tau_distance.sv
// Top level of the Kendall tau distance block.
//
//   channel   direction  handshake                  payload
//   pair      in         pair_valid / pair_stall    elem_first, elem_second, last_pair
//   result    out        result_valid / result_stall distance, bad_input
//
// Loading takes one item per cycle while pair_stall is low; the last item is followed
// by a drain and a check state. A good job then walks n positions; for each one, with c
// the composed value, the walk scans the 32-flag bitmap words from the word of n-1 down
// to the word of c. A clearing pass over bitmap words 0 to max_value/32 follows every
// job, then the output state, which waits until the output register is free.
// Reset starts a clearing pass over every bitmap word (MAX_SIZE/32 rounded up, 8 words
// at the default size) before the first item is taken.
// pair_stall is high during that pass and from the last item until its result enters
// the output register.
module kendall_tau_distance #(
	parameter int MAX_SIZE = ktd_pkg::DEF_MAX_SIZE
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        pair_valid,
	output logic                        pair_stall,
	input  logic [ktd_pkg::ELEM_W-1:0]  elem_first,
	input  logic [ktd_pkg::ELEM_W-1:0]  elem_second,
	input  logic                        last_pair,
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic [ktd_pkg::DIST_W-1:0]  distance,
	output logic                        bad_input
);
	import ktd_pkg::*;

	localparam int IDX_W = $clog2(MAX_SIZE);
	localparam int CNT_W = $clog2(MAX_SIZE + 1);
	localparam int NWORDS = (MAX_SIZE + BM_W - 1) / BM_W;
	localparam int WA_W = (NWORDS > 1) ? $clog2(NWORDS) : 1;

	localparam logic [2:0] ST_LOAD  = 3'd0;
	localparam logic [2:0] ST_DRAIN = 3'd1;
	localparam logic [2:0] ST_CHECK = 3'd2;
	localparam logic [2:0] ST_WALK  = 3'd3;
	localparam logic [2:0] ST_CLEAR = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	logic [2:0]         st_q;
	logic [CNT_W-1:0]   pc_q;
	logic               ovf_q;
	logic [CNT_W-1:0]   n_q;
	logic               good_q;
	logic               init_q;
	logic [WA_W-1:0]    clr_top_q;
	logic [WA_W-1:0]    clr_addr_q;
	logic               result_valid_q;
	logic [DIST_W-1:0]  distance_q;
	logic               bad_q;

	logic               accept;
	logic               store;
	logic               good_now;
	logic               stat_clr;
	logic               clr_en;
	logic               wk_start;
	logic               out_free;
	logic [ELEM_W-1:0]  max_ab;

	logic [CNT_W-1:0]   cnt_a;
	logic [CNT_W-1:0]   cnt_b;
	logic [ELEM_W-1:0]  max_a;
	logic [ELEM_W-1:0]  max_b;
	logic [BM_W-1:0]    bm_data;
	logic [ELEM_W-1:0]  inv_q;
	logic [ELEM_W-1:0]  first_q;
	wk_ctl_t            wk_ctl;
	logic [IDX_W-1:0]   wk_inv_addr;
	logic [IDX_W-1:0]   wk_first_addr;
	logic [WA_W-1:0]    wk_bm_addr;
	logic [BM_W-1:0]    wk_bm_wdata;
	logic               wk_done;
	logic [DIST_W-1:0]  wk_dist;

	// Items are taken only while loading.
	assign pair_stall = (st_q != ST_LOAD);
	assign accept = pair_valid && !pair_stall;
	assign store = accept && (32'(pc_q) < MAX_SIZE) && (32'(elem_first) < MAX_SIZE)
		&& (32'(elem_second) < MAX_SIZE);

	// Both inputs are permutations when n distinct values arrived, all below n.
	assign good_now = !ovf_q && (cnt_a == pc_q) && (cnt_b == pc_q)
		&& (32'(max_a) < 32'(pc_q)) && (32'(max_b) < 32'(pc_q));
	assign max_ab = (max_a > max_b) ? max_a : max_b;

	assign stat_clr = (st_q == ST_CHECK);
	assign wk_start = (st_q == ST_CHECK) && good_now;
	assign clr_en = (st_q == ST_CLEAR);
	assign out_free = !result_valid_q || !result_stall;

	assign result_valid = result_valid_q;
	assign distance = distance_q;
	assign bad_input = bad_q;

	ktd_perm_store #(.MAX_SIZE(MAX_SIZE)) u_perm (
		.clk        (clk),
		.wr_en      (store),
		.wr_pos     (IDX_W'(pc_q)),
		.wr_first   (elem_first),
		.wr_val     (IDX_W'(elem_second)),
		.wr_inv     (ELEM_W'(pc_q)),
		.ctl        (wk_ctl),
		.inv_addr   (wk_inv_addr),
		.first_addr (wk_first_addr),
		.inv_q      (inv_q),
		.first_q    (first_q)
	);

	ktd_bitmap #(.MAX_SIZE(MAX_SIZE)) u_bitmap (
		.clk      (clk),
		.arst_n   (arst_n),
		.ld_en    (store),
		.ld_a     (elem_first),
		.ld_b     (elem_second),
		.stat_clr (stat_clr),
		.clr_en   (clr_en),
		.clr_addr (clr_addr_q),
		.wk_ctl   (wk_ctl),
		.wk_addr  (wk_bm_addr),
		.wk_wdata (wk_bm_wdata),
		.rd_data  (bm_data),
		.cnt_a    (cnt_a),
		.cnt_b    (cnt_b),
		.max_a    (max_a),
		.max_b    (max_b)
	);

	ktd_walk #(.MAX_SIZE(MAX_SIZE)) u_walk (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (wk_start),
		.n          (n_q),
		.inv_q      (inv_q),
		.first_q    (first_q),
		.bm_data    (bm_data),
		.ctl        (wk_ctl),
		.inv_addr   (wk_inv_addr),
		.first_addr (wk_first_addr),
		.bm_addr    (wk_bm_addr),
		.bm_wdata   (wk_bm_wdata),
		.done       (wk_done),
		.distance   (wk_dist)
	);

	// Job sequencer: load, drain, check, walk (good jobs only), clear, deliver.
	// After reset it first clears every bitmap word and then waits for items.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLEAR;
			pc_q <= '0;
			ovf_q <= 1'b0;
			n_q <= '0;
			good_q <= 1'b0;
			init_q <= 1'b1;
			clr_top_q <= WA_W'(NWORDS - 1);
			clr_addr_q <= '0;
		end else begin
			unique case (st_q)
				ST_LOAD: begin
					if (accept) begin
						if (32'(pc_q) < MAX_SIZE) begin
							pc_q <= pc_q + CNT_W'(1);
						end
						if (!store) begin
							ovf_q <= 1'b1;
						end
						if (last_pair) begin
							st_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					st_q <= ST_CHECK;
				end
				ST_CHECK: begin
					n_q <= pc_q;
					good_q <= good_now;
					clr_top_q <= WA_W'(max_ab >> BM_LOG);
					clr_addr_q <= '0;
					pc_q <= '0;
					ovf_q <= 1'b0;
					st_q <= good_now ? ST_WALK : ST_CLEAR;
				end
				ST_WALK: begin
					if (wk_done) begin
						st_q <= ST_CLEAR;
					end
				end
				ST_CLEAR: begin
					if (clr_addr_q == clr_top_q) begin
						if (init_q) begin
							init_q <= 1'b0;
							st_q <= ST_LOAD;
						end else begin
							st_q <= ST_OUT;
						end
					end else begin
						clr_addr_q <= clr_addr_q + WA_W'(1);
					end
				end
				ST_OUT: begin
					if (out_free) begin
						st_q <= ST_LOAD;
					end
				end
				default: begin
					st_q <= ST_LOAD;
				end
			endcase
		end
	end

	// Output valid: set when a result is loaded, cleared once it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (st_q == ST_OUT && out_free) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (st_q == ST_OUT && out_free) begin
			distance_q <= good_q ? wk_dist : '0;
			bad_q <= !good_q;
		end
	end

endmodule

### verif/tb_top.sv
// Self-checking testbench for the Kendall tau distance block.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ktd_pkg::*;

	localparam int CAP = DEF_MAX_SIZE;
	localparam int RAND_ITEMS = 280;
	localparam int CYCLE_LIMIT = 400000;
	// Long enough for the longest job: 256 positions plus clearing and output.
	localparam int TAIL_CYCLES = 3000;
	localparam int SHOWN_FAILS = 10;

	typedef logic [ELEM_W-1:0] elem_t;
	typedef elem_t elem_q_t [$];

	// One expected result item.
	typedef struct {
		logic [DIST_W-1:0] dist_val;
		logic              bad;
	} dist_result_t;

	// Ways a generated job is built or broken.
	typedef enum int {
		JOB_PERM,
		JOB_DUP_FIRST,
		JOB_DUP_SECOND,
		JOB_OUT_OF_RANGE,
		JOB_NOISE
	} job_kind_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              pair_valid;
	logic              pair_stall;
	logic [ELEM_W-1:0] elem_first;
	logic [ELEM_W-1:0] elem_second;
	logic              last_pair;
	logic              result_valid;
	logic              result_stall;
	logic [DIST_W-1:0] distance;
	logic              bad_input;

	kendall_tau_distance #(
		.MAX_SIZE(CAP)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.pair_valid(pair_valid),
		.pair_stall(pair_stall),
		.elem_first(elem_first),
		.elem_second(elem_second),
		.last_pair(last_pair),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.distance(distance),
		.bad_input(bad_input)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mirror of the job being loaded: first permutation, inverse of the second.
	elem_t perm_first [CAP];
	elem_t inv_second [CAP];
	bit    hit_first [CAP];
	bit    hit_second [CAP];
	int    loaded;
	bit    spilled;

	dist_result_t due_dist [$];
	int fail_count = 0;
	int cycle_count = 0;
	int rx_hold = 0;
	bit tx_burst = 1'b0;
	bit rx_burst = 1'b0;
	int rand_items = 0;

	function automatic void clear_job();
		for (int k = 0; k < CAP; k++) begin
			perm_first[k] = '0;
			inv_second[k] = '0;
			hit_first[k] = 1'b0;
			hit_second[k] = 1'b0;
		end
		loaded = 0;
		spilled = 1'b0;
	endfunction

	// Fold one accepted pair into the job; on the last pair, predict the distance.
	function automatic void score_pair(input elem_t a, input elem_t b, input logic lst);
		dist_result_t res;
		int n;
		int cnt;
		bit good;
		int comp [CAP];
		if (loaded >= CAP || a >= CAP || b >= CAP) begin
			spilled = 1'b1;
		end else begin
			perm_first[loaded] = a;
			inv_second[b] = loaded[ELEM_W-1:0];
			hit_first[a] = 1'b1;
			hit_second[b] = 1'b1;
		end
		if (loaded < CAP)
			loaded++;
		if (!lst)
			return;

		// Both sequences must cover 0..n-1, otherwise the job is flagged.
		n = loaded;
		good = !spilled;
		for (int v = 0; v < n; v++)
			if (!hit_first[v] || !hit_second[v])
				good = 1'b0;

		// Count inversions of the composition first[inverse_second[i]].
		cnt = 0;
		if (good) begin
			for (int i = 0; i < n; i++)
				comp[i] = perm_first[inv_second[i]];
			for (int i = 0; i < n; i++)
				for (int j = i + 1; j < n; j++)
					if (comp[i] > comp[j])
						cnt++;
			if (cnt > DIST_MAX)
				cnt = DIST_MAX;
		end
		res.dist_val = cnt[DIST_W-1:0];
		res.bad = !good;
		due_dist = {due_dist, res};
		clear_job();
	endfunction

	function automatic void check_result(input logic [DIST_W-1:0] got_d, input logic got_b);
		dist_result_t want;
		if (due_dist.size() == 0) begin
			fail_count++;
			if (fail_count <= SHOWN_FAILS)
				$display("unexpected result item: distance %0d bad_input %0b", got_d, got_b);
			return;
		end
		want = due_dist.pop_front();
		if (got_d !== want.dist_val || got_b !== want.bad) begin
			fail_count++;
			if (fail_count <= SHOWN_FAILS)
				$display("mismatch at %0t: distance exp %0d got %0d, bad_input exp %0b got %0b",
					$realtime, want.dist_val, got_d, want.bad, got_b);
		end
	endfunction

	// Result side: check each accepted item, then hold off a random number of cycles.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && result_valid === 1'b1 && result_stall === 1'b0) begin
			check_result(distance, bad_input);
			rx_hold = rx_burst ? 0 : $urandom_range(0, 7);
		end else if (rx_hold > 0) begin
			rx_hold--;
		end
		result_stall <= (rx_hold > 0);
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Send one item after a random gap and wait until it is taken.
	task automatic send_pair(input elem_t a, input elem_t b, input logic lst);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			pair_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pair_valid <= 1'b1;
		elem_first <= a;
		elem_second <= b;
		last_pair <= lst;
		do
			@(posedge clk);
		while (pair_stall !== 1'b0);
		score_pair(a, b, lst);
	endtask

	task automatic send_job(input elem_q_t fa, input elem_q_t sb);
		for (int k = 0; k < fa.size(); k++)
			send_pair(fa[k], sb[k], k == fa.size() - 1);
	endtask

	// Hold the sender back until every pending result has come out.
	task automatic wait_drained();
		pair_valid <= 1'b0;
		do
			@(posedge clk);
		while (due_dist.size() != 0);
	endtask

	function automatic elem_q_t random_perm(input int n);
		elem_q_t q;
		int j;
		elem_t t;
		for (int k = 0; k < n; k++)
			q = {q, k[ELEM_W-1:0]};
		for (int k = n - 1; k > 0; k--) begin
			j = $urandom_range(0, k);
			t = q[k];
			q[k] = q[j];
			q[j] = t;
		end
		return q;
	endfunction

	// Build a job of n pairs of the given kind and send it.
	task automatic run_job(input int n, input job_kind_t kind);
		elem_q_t fa;
		elem_q_t sb;
		int i;
		int j;
		fa = random_perm(n);
		sb = random_perm(n);
		if (kind == JOB_OUT_OF_RANGE && n >= 256)
			kind = JOB_DUP_FIRST;
		if ((kind == JOB_DUP_FIRST || kind == JOB_DUP_SECOND) && n < 2)
			kind = JOB_OUT_OF_RANGE;
		i = $urandom_range(0, n - 1);
		j = (i + $urandom_range(1, (n > 1) ? n - 1 : 1)) % n;
		case (kind)
			JOB_DUP_FIRST: begin
				fa[j] = fa[i];
			end
			JOB_DUP_SECOND: begin
				sb[j] = sb[i];
			end
			JOB_OUT_OF_RANGE: begin
				if ($urandom_range(0, 1))
					fa[i] = elem_t'($urandom_range(n, 255));
				else
					sb[i] = elem_t'($urandom_range(n, 255));
			end
			JOB_NOISE: begin
				for (int k = 0; k < n; k++) begin
					fa[k] = elem_t'($urandom_range(0, 255));
					sb[k] = elem_t'($urandom_range(0, 255));
				end
			end
			default: begin
			end
		endcase
		send_job(fa, sb);
	endtask

	// Tiny jobs, swaps, a full reversal and each kind of malformed input.
	task automatic test_directed();
		elem_q_t fa;
		elem_q_t sb;
		send_job('{8'd0}, '{8'd0});
		send_job('{8'd1}, '{8'd0});
		send_job('{8'd0}, '{8'd255});
		send_job('{8'd0, 8'd1}, '{8'd1, 8'd0});
		send_job('{8'd1, 8'd0}, '{8'd1, 8'd0});
		send_job('{8'd0, 8'd0}, '{8'd0, 8'd1});
		send_job('{8'd0, 8'd1}, '{8'd1, 8'd1});
		send_job('{8'd255, 8'd0, 8'd1}, '{8'd0, 8'd1, 8'd2});
		for (int k = 0; k < 8; k++) begin
			fa = {fa, elem_t'(7 - k)};
			sb = {sb, elem_t'(k)};
		end
		send_job(fa, sb);
	endtask

	// Full capacity: largest distance, a random pair, and jobs too long to store.
	task automatic test_capacity();
		elem_q_t fa;
		elem_q_t sb;
		tx_burst = 1'b1;
		for (int k = 0; k < CAP; k++) begin
			fa = {fa, elem_t'(CAP - 1 - k)};
			sb = {sb, elem_t'(k)};
		end
		send_job(fa, sb);
		tx_burst = 1'b0;
		run_job(CAP, JOB_PERM);
		fa = random_perm(CAP);
		sb = random_perm(CAP);
		fa = {fa, 8'd0};
		sb = {sb, 8'd0};
		send_job(fa, sb);
		fa = random_perm(CAP);
		sb = random_perm(CAP);
		for (int k = 0; k < 3; k++) begin
			fa = {fa, elem_t'($urandom_range(0, 255))};
			sb = {sb, elem_t'($urandom_range(0, 255))};
		end
		send_job(fa, sb);
	endtask

	// The sender goes quiet until the block has returned every result.
	task automatic test_drain_pause();
		for (int k = 0; k < 4; k++) begin
			run_job($urandom_range(1, 12), JOB_PERM);
			wait_drained();
		end
		run_job(5, JOB_DUP_SECOND);
		wait_drained();
	endtask

	// Mostly well-formed jobs of random size, with broken jobs and noise mixed in.
	task automatic test_random();
		int pick;
		int n;
		job_kind_t kind;
		while (rand_items < RAND_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 70)
				n = $urandom_range(1, 8);
			else if (pick < 92)
				n = $urandom_range(9, 32);
			else if (pick < 98)
				n = $urandom_range(33, 128);
			else
				n = $urandom_range(129, CAP);
			pick = $urandom_range(0, 99);
			if (pick < 75)
				kind = JOB_PERM;
			else if (pick < 82)
				kind = JOB_DUP_FIRST;
			else if (pick < 89)
				kind = JOB_DUP_SECOND;
			else if (pick < 95)
				kind = JOB_OUT_OF_RANGE;
			else
				kind = JOB_NOISE;
			// Some jobs run without idling on one side or both.
			tx_burst = ($urandom_range(0, 4) == 0);
			rx_burst = ($urandom_range(0, 4) == 0);
			run_job(n, kind);
			rand_items += n;
		end
		tx_burst = 1'b0;
		rx_burst = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		pair_valid = 1'b0;
		elem_first = '0;
		elem_second = '0;
		last_pair = 1'b0;
		result_stall = 1'b0;
		clear_job();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_capacity();
		test_drain_pause();
		test_random();

		// Let the last job finish and make sure nothing extra comes out.
		pair_valid <= 1'b0;
		do
			@(posedge clk);
		while (due_dist.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
